>>> src/iqrc_pkg.sv
package iqrc_pkg;

  localparam int QW = 16;
  localparam int CODE_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W = 35;

  localparam logic signed [QW-1:0] Q_ONE = 16'sd16384;
  localparam logic signed [QW-1:0] Q_MAX = 16'sd32767;
  localparam logic signed [QW-1:0] Q_MIN = -16'sd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAP_Z = 2'd2;

  localparam logic [CODE_W-1:0] AXIS_MAP_X_RST = 3'd0;
  localparam logic [CODE_W-1:0] AXIS_MAP_Y_RST = 3'd2;
  localparam logic [CODE_W-1:0] AXIS_MAP_Z_RST = 3'd4;

  localparam logic [1:0] SRC_X = 2'd0;
  localparam logic [1:0] SRC_Y = 2'd1;
  localparam logic [1:0] SRC_Z = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CAL = 1'b1;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic                 req_type;
    logic signed [QW-1:0] raw_w;
    logic signed [QW-1:0] raw_x;
    logic signed [QW-1:0] raw_y;
    logic signed [QW-1:0] raw_z;
  } iqrc_in_t;

  typedef struct packed {
    logic signed [QW-1:0] out_w;
    logic signed [QW-1:0] out_x;
    logic signed [QW-1:0] out_y;
    logic signed [QW-1:0] out_z;
  } iqrc_out_t;

  // Negation that maps the most negative value to the most positive one.
  function automatic logic signed [QW-1:0] neg_sat(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    if (v == Q_MIN) begin
      r = Q_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

>>> src/iqrc_remap.sv
module iqrc_remap import iqrc_pkg::*; (
  input  quat_t             raw,
  input  logic [CODE_W-1:0] map_x,
  input  logic [CODE_W-1:0] map_y,
  input  logic [CODE_W-1:0] map_z,
  output quat_t             remapped
);

  function automatic logic signed [QW-1:0] pick(input logic [CODE_W-1:0] code,
                                                input quat_t q);
    logic signed [QW-1:0] v;
    unique case (code[2:1])
      SRC_X:   v = q.x;
      SRC_Y:   v = q.y;
      SRC_Z:   v = q.z;
      default: v = '0;
    endcase
    if (code[0]) begin
      v = neg_sat(v);
    end
    return v;
  endfunction

  // Codes six and seven select no axis; pick returns zero for them, and
  // negating zero leaves zero.
  always_comb begin
    remapped.w = raw.w;
    remapped.x = pick(map_x, raw);
    remapped.y = pick(map_y, raw);
    remapped.z = pick(map_z, raw);
  end

endmodule

>>> src/iqrc_hamilton.sv
module iqrc_hamilton import iqrc_pkg::*; (
  input  quat_t a,
  input  quat_t c,
  output quat_t p
);

  function automatic logic signed [ACC_W-1:0] mul(input logic signed [QW-1:0] u,
                                                  input logic signed [QW-1:0] v);
    logic signed [2*QW-1:0] m;
    m = u * v;
    return ACC_W'(m);
  endfunction

  // Adds half an LSB, floors by 14 bits and clamps to the Q2.14 range.
  function automatic logic signed [QW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]    t;
    logic signed [ACC_W-15:0]   s;
    logic signed [QW-1:0]       r;
    t = acc + ACC_W'(8192);
    s = t[ACC_W-1:14];
    if (s > (ACC_W-14)'(32767)) begin
      r = Q_MAX;
    end else if (s < -(ACC_W-14)'(32768)) begin
      r = Q_MIN;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  logic signed [ACC_W-1:0] acc_w, acc_x, acc_y, acc_z;

  always_comb begin
    acc_w = mul(a.w, c.w) - mul(a.x, c.x) - mul(a.y, c.y) - mul(a.z, c.z);
    acc_x = mul(a.w, c.x) + mul(a.x, c.w) + mul(a.y, c.z) - mul(a.z, c.y);
    acc_y = mul(a.w, c.y) - mul(a.x, c.z) + mul(a.y, c.w) + mul(a.z, c.x);
    acc_z = mul(a.w, c.z) + mul(a.x, c.y) - mul(a.y, c.x) + mul(a.z, c.w);
    p.w = round_sat(acc_w);
    p.x = round_sat(acc_x);
    p.y = round_sat(acc_y);
    p.z = round_sat(acc_z);
  end

endmodule

>>> src/imu_quaternion_remap_calibrate.sv
// IMU orientation remap and calibration.
// Input channel (in_valid, in_stall, in_data): one word per raw quaternion in
// signed Q2.14. A word with req_type set captures the conjugate of the
// remapped quaternion as the new calibration and produces no result; any
// other word produces one result word, the remapped quaternion times the
// calibration, rounded and saturated to Q2.14.
// Result channel (out_valid, out_stall, out_data): a word is taken at an edge
// where out_valid is high and out_stall is low.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): the three axis
// codes, always ready; writes to index three are dropped. Write only while idle.
// From input acceptance to out_valid a word passes the input register, then
// the remap and the sixteen-multiply product, then the result register.
// Throughput is one word per cycle unless stalled; a calibrate word updates the
// stored calibration as it leaves the input register, so the next word sees it.
// When the receiver stalls, the result register holds and the input register
// holds a sample behind it, so in_stall rises after one more sample word at
// most; calibrate words keep draining meanwhile.
// Reset clears both registers' valid flags, restores the axis codes to x, y, z
// and sets the calibration to the identity quaternion.
module imu_quaternion_remap_calibrate import iqrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iqrc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iqrc_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data
);

  logic [CODE_W-1:0] map_x_r, map_y_r, map_z_r;
  quat_t             cal_r;
  logic              s1_valid_r;
  iqrc_in_t          s1_data_r;
  logic              out_valid_r;
  iqrc_out_t         out_data_r;

  quat_t raw_q, remap_q, prod_q;
  logic  out_adv, s1_go, s1_free, s1_is_cal;

  assign raw_q.w = s1_data_r.raw_w;
  assign raw_q.x = s1_data_r.raw_x;
  assign raw_q.y = s1_data_r.raw_y;
  assign raw_q.z = s1_data_r.raw_z;

  iqrc_remap u_remap (
    .raw      (raw_q),
    .map_x    (map_x_r),
    .map_y    (map_y_r),
    .map_z    (map_z_r),
    .remapped (remap_q)
  );

  iqrc_hamilton u_hamilton (
    .a (remap_q),
    .c (cal_r),
    .p (prod_q)
  );

  assign s1_is_cal = (s1_data_r.req_type == REQ_CAL);
  assign out_adv   = !out_valid_r || !out_stall;
  // A calibrate word never needs the result register, so it always drains.
  assign s1_go     = s1_valid_r && (s1_is_cal || out_adv);
  assign s1_free   = !s1_valid_r || s1_go;
  assign in_stall  = !s1_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_x_r     <= AXIS_MAP_X_RST;
      map_y_r     <= AXIS_MAP_Y_RST;
      map_z_r     <= AXIS_MAP_Z_RST;
      cal_r.w     <= Q_ONE;
      cal_r.x     <= '0;
      cal_r.y     <= '0;
      cal_r.z     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_AXIS_MAP_X: map_x_r <= cfg_data;
          CFG_AXIS_MAP_Y: map_y_r <= cfg_data;
          CFG_AXIS_MAP_Z: map_z_r <= cfg_data;
          default: ;
        endcase
      end

      if (s1_free) begin
        s1_valid_r <= in_valid;
      end

      if (s1_go && s1_is_cal) begin
        cal_r.w <= remap_q.w;
        cal_r.x <= neg_sat(remap_q.x);
        cal_r.y <= neg_sat(remap_q.y);
        cal_r.z <= neg_sat(remap_q.z);
      end

      if (out_adv) begin
        out_valid_r <= s1_go && !s1_is_cal;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_data_r <= in_data;
    end
    if (out_adv && s1_go && !s1_is_cal) begin
      out_data_r.out_w <= prod_q.w;
      out_data_r.out_x <= prod_q.x;
      out_data_r.out_y <= prod_q.y;
      out_data_r.out_z <= prod_q.z;
    end
  end

endmodule

>>> bench/tb.sv
module tb import iqrc_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned WORDS_PER_PHASE = 140;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned REPORT_LIMIT = 10;
  // Index three has no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  iqrc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  iqrc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0] cfg_data = '0;

  // Mirror of the block's axis codes and stored calibration.
  logic [CODE_W-1:0] map_x = AXIS_MAP_X_RST;
  logic [CODE_W-1:0] map_y = AXIS_MAP_Y_RST;
  logic [CODE_W-1:0] map_z = AXIS_MAP_Z_RST;
  logic signed [QW-1:0] cal_w = Q_ONE;
  logic signed [QW-1:0] cal_x = '0;
  logic signed [QW-1:0] cal_y = '0;
  logic signed [QW-1:0] cal_z = '0;

  iqrc_out_t pending_quats[$];

  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned cal_words = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;

  imu_quaternion_remap_calibrate uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [QW-1:0] negate_q(input logic signed [QW-1:0] v);
    if (v == Q_MIN) begin
      return Q_MAX;
    end
    return -v;
  endfunction

  function automatic logic signed [QW-1:0] remap_axis(input logic [CODE_W-1:0] code,
      input logic signed [QW-1:0] sx, input logic signed [QW-1:0] sy,
      input logic signed [QW-1:0] sz);
    logic signed [QW-1:0] v;
    case (code[2:1])
      SRC_X: v = sx;
      SRC_Y: v = sy;
      SRC_Z: v = sz;
      default: return '0;
    endcase
    return code[0] ? negate_q(v) : v;
  endfunction

  function automatic logic signed [QW-1:0] round_q(input longint acc);
    longint r;
    r = (acc + 64'sd8192) >>> 14;
    if (r > 32767) begin
      return Q_MAX;
    end
    if (r < -32768) begin
      return Q_MIN;
    end
    return r[QW-1:0];
  endfunction

  // Returns 1 and the calibrated quaternion for a sample word; a calibrate
  // word only replaces the stored calibration.
  function automatic bit remap_and_calibrate(input iqrc_in_t w, output iqrc_out_t q);
    logic signed [QW-1:0] rx, ry, rz;
    longint aw, ax, ay, az, bw, bx, by, bz;
    rx = remap_axis(map_x, w.raw_x, w.raw_y, w.raw_z);
    ry = remap_axis(map_y, w.raw_x, w.raw_y, w.raw_z);
    rz = remap_axis(map_z, w.raw_x, w.raw_y, w.raw_z);
    if (w.req_type == REQ_CAL) begin
      cal_w = w.raw_w;
      cal_x = negate_q(rx);
      cal_y = negate_q(ry);
      cal_z = negate_q(rz);
      return 1'b0;
    end
    aw = w.raw_w;
    ax = rx;
    ay = ry;
    az = rz;
    bw = cal_w;
    bx = cal_x;
    by = cal_y;
    bz = cal_z;
    q.out_w = round_q(aw * bw - ax * bx - ay * by - az * bz);
    q.out_x = round_q(aw * bx + ax * bw + ay * bz - az * by);
    q.out_y = round_q(aw * by - ax * bz + ay * bw + az * bx);
    q.out_z = round_q(aw * bz + ax * by - ay * bx + az * bw);
    return 1'b1;
  endfunction

  function automatic iqrc_in_t make_word(input logic req, input logic signed [QW-1:0] w,
      input logic signed [QW-1:0] x, input logic signed [QW-1:0] y,
      input logic signed [QW-1:0] z);
    iqrc_in_t d;
    d.req_type = req;
    d.raw_w = w;
    d.raw_x = x;
    d.raw_y = y;
    d.raw_z = z;
    return d;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 92) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [QW-1:0] rand_q();
    logic [31:0] bits;
    int near;
    bits = $urandom();
    near = $urandom_range(0, 4095) - 2048;
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      4: return near[QW-1:0];
      default: return bits[QW-1:0];
    endcase
  endfunction

  task automatic send_word(input iqrc_in_t w);
    int unsigned gap;
    iqrc_out_t q;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 99) < 30) begin
      gap = idle_len();
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (w.req_type == REQ_CAL) begin
      cal_words++;
    end
    if (remap_and_calibrate(w, q)) begin
      pending_quats = {pending_quats, q};
    end
  endtask

  // A calibrate word can still sit in the pipeline after the last result,
  // so the task keeps waiting after the queue empties before the axis codes may change.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      CFG_AXIS_MAP_X: map_x = val;
      CFG_AXIS_MAP_Y: map_y = val;
      CFG_AXIS_MAP_Z: map_z = val;
      default: ;
    endcase
  endtask

  task automatic program_axes(input logic [CODE_W-1:0] x, input logic [CODE_W-1:0] y,
      input logic [CODE_W-1:0] z);
    cfg_write(CFG_AXIS_MAP_X, x);
    cfg_write(CFG_AXIS_MAP_Y, y);
    cfg_write(CFG_AXIS_MAP_Z, z);
    cfg_valid <= 1'b0;
  endtask

  // With the reset calibration every sample comes back unchanged.
  task automatic test_identity_passthrough();
    send_word(make_word(REQ_SAMPLE, '0, '0, '0, '0));
    send_word(make_word(REQ_SAMPLE, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_word(make_word(REQ_SAMPLE, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_word(make_word(REQ_SAMPLE, Q_ONE, '0, '0, '0));
    send_word(make_word(REQ_SAMPLE, -16'sd1, 16'sd1, -Q_ONE, 16'sd12345));
  endtask

  task automatic test_calibration_capture();
    // The conjugate of the most negative part saturates.
    send_word(make_word(REQ_CAL, Q_ONE, Q_MIN, Q_MAX, '0));
    send_word(make_word(REQ_SAMPLE, Q_ONE, '0, '0, '0));
    send_word(make_word(REQ_SAMPLE, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_word(make_word(REQ_SAMPLE, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_word(make_word(REQ_CAL, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_word(make_word(REQ_SAMPLE, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_word(make_word(REQ_SAMPLE, 16'sd1, -16'sd1, 16'sd1, -16'sd1));
    // A half scalar makes the products land exactly on rounding ties.
    send_word(make_word(REQ_CAL, 16'sd8192, '0, '0, '0));
    send_word(make_word(REQ_SAMPLE, 16'sd1, -16'sd1, 16'sd3, -16'sd3));
    send_word(make_word(REQ_SAMPLE, -16'sd1, 16'sd1, -16'sd3, 16'sd3));
  endtask

  task automatic test_axis_remap();
    drain_pipeline();
    cfg_write(CFG_UNMAPPED, 3'd7);
    program_axes(3'd1, 3'd3, 3'd5);
    send_word(make_word(REQ_CAL, Q_ONE, '0, '0, '0));
    send_word(make_word(REQ_SAMPLE, 16'sd100, Q_MIN, 16'sd5, -16'sd7));
    drain_pipeline();
    program_axes(3'd6, 3'd7, 3'd0);
    send_word(make_word(REQ_SAMPLE, 16'sd200, 16'sd11, Q_MIN, Q_MAX));
    drain_pipeline();
    program_axes(3'd4, 3'd0, 3'd2);
    send_word(make_word(REQ_SAMPLE, -16'sd300, 16'sd21, -16'sd22, 16'sd23));
  endtask

  task automatic test_random_stream();
    iqrc_in_t w;
    iqrc_in_t last_cal;
    last_cal = make_word(REQ_CAL, Q_ONE, '0, '0, '0);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_pipeline();
      case (p)
        0: program_axes(3'd2, 3'd4, 3'd0);
        1: program_axes(3'd1, 3'd3, 3'd5);
        2: program_axes(3'd7, 3'd6, 3'd7);
        3: program_axes(3'd0, 3'd0, 3'd0);
        default: program_axes(CODE_W'($urandom_range(0, 7)), CODE_W'($urandom_range(0, 7)),
                               CODE_W'($urandom_range(0, 7)));
      endcase
      // One phase runs with no idling on either side.
      sender_gaps = (p != 3);
      sink_stalls = (p != 3);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        w = make_word(REQ_SAMPLE, rand_q(), rand_q(), rand_q(), rand_q());
        if ($urandom_range(0, 99) < 15) begin
          w.req_type = REQ_CAL;
          last_cal = w;
        end else if ($urandom_range(0, 99) < 10) begin
          // Now and then the last calibration pose is sent again as a sample.
          w = last_cal;
          w.req_type = REQ_SAMPLE;
        end
        send_word(w);
      end
    end
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    iqrc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_quats.size() == 0) begin
        if (errors < REPORT_LIMIT) begin
          $display("ERROR: result word with nothing expected: w=%0d x=%0d y=%0d z=%0d",
                   out_data.out_w, out_data.out_x, out_data.out_y, out_data.out_z);
        end
        errors++;
      end else begin
        want = pending_quats.pop_front();
        results_checked++;
        if (out_data.out_w !== want.out_w || out_data.out_x !== want.out_x ||
            out_data.out_y !== want.out_y || out_data.out_z !== want.out_z) begin
          if (errors < REPORT_LIMIT) begin
            $display("ERROR: result %0d expected w=%0d x=%0d y=%0d z=%0d", results_checked,
                     want.out_w, want.out_x, want.out_y, want.out_z);
            $display("       got w=%0d x=%0d y=%0d z=%0d",
                     out_data.out_w, out_data.out_x, out_data.out_y, out_data.out_z);
          end
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("imu_quaternion_remap_calibrate regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_identity_passthrough();
    test_calibration_capture();
    test_axis_remap();
    test_random_stream();
    drain_pipeline();
    if (pending_quats.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", pending_quats.size());
      errors++;
    end
    $display("Sent %0d words (%0d calibrations), checked %0d results, made %0d register writes.",
             words_sent, cal_words, results_checked, cfg_writes);
    $display("Axis codes ranged from all zero to the unmapped codes, with and without stalls.");
    if (errors == 0) begin
      $display("imu_quaternion_remap_calibrate regression: pass");
    end else begin
      $display("imu_quaternion_remap_calibrate regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/iqrc_pkg.sv
src/iqrc_remap.sv
src/iqrc_hamilton.sv
src/imu_quaternion_remap_calibrate.sv
bench/tb.sv
